>>> rtl/arenc_pkg.sv
// shared types and constants for the arithmetic encoder step core
package arenc_pkg;

    localparam int FOLLOW_W = 16;
    localparam logic [FOLLOW_W-1:0] PEND_MAX = '1;
    localparam int TOTAL_RESET = 256;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
    } lane_ctrl_t;

endpackage

>>> rtl/arenc_if.sv
// handshake interfaces for the symbol and code channels
interface arenc_sym_if #(
    parameter int COUNT_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [COUNT_BITS-1:0] cum_low;
    logic [COUNT_BITS-1:0] cum_high;

    modport source (output valid, output func, output cum_low, output cum_high, input ready);
    modport sink (input valid, input func, input cum_low, input cum_high, output ready);
endinterface

interface arenc_code_if import arenc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                bit_value;
    logic [FOLLOW_W-1:0] follow_count;
    logic                last;

    modport source (output valid, output bit_value, output follow_count, output last,
                    input ready);
    modport sink (input valid, input bit_value, input follow_count, input last,
                  output ready);
endinterface

>>> rtl/arenc_scale_lane.sv
// bit-serial multiply then restoring divide: floor(range * count / total)
module arenc_scale_lane import arenc_pkg::*; #(
    parameter int PRECISION  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_ctrl_t            ctrl,
    input  logic [PRECISION:0]    range_val,
    input  logic [COUNT_BITS-1:0] count_val,
    input  logic [COUNT_BITS-1:0] total_val,
    output logic [PRECISION:0]    quot
);

    localparam int W = PRECISION + COUNT_BITS + 1;

    logic [W-1:0]          acc_reg;
    logic [W-1:0]          acc_next;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] rem_next;
    logic [COUNT_BITS-1:0] cnt_sh_reg;
    logic [COUNT_BITS-1:0] cnt_sh_next;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  ge;

    assign trial = {rem_reg, acc_reg[W-1]};
    assign ge    = trial >= {1'b0, total_val};
    assign diff  = trial - {1'b0, total_val};

    always_comb
    begin
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        cnt_sh_next = cnt_sh_reg;
        if (ctrl.load)
        begin
            acc_next    = '0;
            rem_next    = '0;
            cnt_sh_next = count_val;
        end
        else if (ctrl.mul)
        begin
            acc_next    = {acc_reg[W-2:0], 1'b0}
                          + (cnt_sh_reg[COUNT_BITS-1] ? W'(range_val) : '0);
            cnt_sh_next = {cnt_sh_reg[COUNT_BITS-2:0], 1'b0};
        end
        else if (ctrl.div)
        begin
            acc_next = {acc_reg[W-2:0], ge};
            rem_next = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            rem_reg    <= '0;
            cnt_sh_reg <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            cnt_sh_reg <= cnt_sh_next;
        end
    end

    assign quot = acc_reg[PRECISION:0];

endmodule

>>> rtl/arithmetic_encoder_step_core.sv
// arithmetic encoder step core: interval narrowing with deferred carry bits
//
// sym channel: one beat per item; func 0 narrows the interval by cum_low and
// cum_high out of the configured total, func 1 finishes the stream.
// code channel: one beat per decided bit with the count of inverted bits
// that follow it; last marks the final beat caused by an item. a symbol that
// needs no output bit gives no beat at all.
// total register: the user must write it through cfg_wr_en / cfg_wr_data
// only while idle; the block itself does not enforce this.
// a symbol goes through bit-serial multiply and restoring divide, the
// interval update and the renormalisation shifts, then hands over any
// held beat. the multiply and divide lanes step one bit per cycle and
// set the symbol time; one item is worked on at a time.
// reset: interval to the full code range, deferred count cleared, total 256.
// a stalled receiver holds the output register; renormalisation and
// finish wait while a beat must move into that register and it is full.
module arithmetic_encoder_step_core import arenc_pkg::*; #(
    parameter int PRECISION  = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [COUNT_BITS-1:0] cfg_wr_data,
    arenc_sym_if.sink             sym,
    arenc_code_if.source          code
);

    localparam int W     = PRECISION + COUNT_BITS + 1;
    localparam int CNT_W = $clog2(W + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_UPD    = 3'd3;
    localparam logic [2:0] ST_RENORM = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [PRECISION-1:0]  low_reg, low_next;
    logic [PRECISION-1:0]  high_reg, high_next;
    logic [FOLLOW_W-1:0]   pend_reg, pend_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic                  hold_bit_reg, hold_bit_next;
    logic [FOLLOW_W-1:0]   hold_follow_reg, hold_follow_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_bit_reg, out_bit_next;
    logic [FOLLOW_W-1:0]   out_follow_reg, out_follow_next;
    logic                  out_last_reg, out_last_next;

    lane_ctrl_t            ctrl;
    logic [COUNT_BITS-1:0] tot_eff;
    logic [COUNT_BITS-1:0] ch_a, ch_c, cl_c;
    logic [PRECISION:0]    range_val;
    logic [PRECISION:0]    hi_q, lo_q, hi_off;
    logic [FOLLOW_W-1:0]   pend_inc;
    logic                  out_free;
    logic                  emit0, emit1, mid;

    assign tot_eff   = (total_reg == '0) ? COUNT_BITS'(1) : total_reg;
    assign ch_a      = (sym.cum_high > tot_eff) ? tot_eff : sym.cum_high;
    assign ch_c      = (ch_a == '0) ? COUNT_BITS'(1) : ch_a;
    assign cl_c      = (sym.cum_low >= ch_c) ? ch_c - COUNT_BITS'(1) : sym.cum_low;
    assign range_val = {1'b0, high_reg} - {1'b0, low_reg} + (PRECISION+1)'(1);
    assign hi_off    = (hi_q <= lo_q) ? lo_q + (PRECISION+1)'(1) : hi_q;
    assign pend_inc  = (pend_reg == PEND_MAX) ? pend_reg : pend_reg + FOLLOW_W'(1);
    assign out_free  = !out_valid_reg || code.ready;
    assign emit0     = !high_reg[PRECISION-1];
    assign emit1     = low_reg[PRECISION-1];
    assign mid       = (low_reg[PRECISION-1:PRECISION-2] == 2'b01)
                       && (high_reg[PRECISION-1:PRECISION-2] == 2'b10);

    arenc_scale_lane #(
        .PRECISION  (PRECISION),
        .COUNT_BITS (COUNT_BITS)
    ) u_lane_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .range_val (range_val),
        .count_val (ch_c),
        .total_val (tot_eff),
        .quot      (hi_q)
    );

    arenc_scale_lane #(
        .PRECISION  (PRECISION),
        .COUNT_BITS (COUNT_BITS)
    ) u_lane_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .range_val (range_val),
        .count_val (cl_c),
        .total_val (tot_eff),
        .quot      (lo_q)
    );

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        total_next       = total_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        pend_next        = pend_reg;
        hold_valid_next  = hold_valid_reg;
        hold_bit_next    = hold_bit_reg;
        hold_follow_next = hold_follow_reg;
        out_valid_next   = out_valid_reg;
        out_bit_next     = out_bit_reg;
        out_follow_next  = out_follow_reg;
        out_last_next    = out_last_reg;
        ctrl             = '0;

        if (cfg_wr_en)
        begin
            total_next = cfg_wr_data;
        end
        if (out_valid_reg && code.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sym.valid)
                begin
                    if (sym.func)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ctrl.load  = 1'b1;
                        cnt_next   = CNT_W'(COUNT_BITS);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                ctrl.mul = 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(W);
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DIV:
            begin
                ctrl.div = 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_UPD:
            begin
                high_next  = low_reg + hi_off[PRECISION-1:0] - PRECISION'(1);
                low_next   = low_reg + lo_q[PRECISION-1:0];
                state_next = ST_RENORM;
            end
            ST_RENORM:
            begin
                if (emit0 || emit1)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_bit_next    = hold_bit_reg;
                            out_follow_next = hold_follow_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next  = 1'b1;
                        hold_bit_next    = !emit0;
                        hold_follow_next = pend_reg;
                        pend_next        = '0;
                        low_next         = {low_reg[PRECISION-2:0], 1'b0};
                        high_next        = {high_reg[PRECISION-2:0], 1'b1};
                    end
                end
                else if (mid)
                begin
                    // middle half: drop a quarter and defer the bit
                    pend_next = pend_inc;
                    low_next  = {1'b0, low_reg[PRECISION-3:0], 1'b0};
                    high_next = {1'b1, high_reg[PRECISION-3:0], 1'b1};
                end
                else if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bit_next    = hold_bit_reg;
                    out_follow_next = hold_follow_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bit_next    = |low_reg[PRECISION-1:PRECISION-2];
                    out_follow_next = pend_inc;
                    out_last_next   = 1'b1;
                    low_next        = '0;
                    high_next       = '1;
                    pend_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            total_reg      <= COUNT_BITS'(TOTAL_RESET);
            low_reg        <= '0;
            high_reg       <= '1;
            pend_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            total_reg      <= total_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_bit_reg    <= hold_bit_next;
        hold_follow_reg <= hold_follow_next;
        out_bit_reg     <= out_bit_next;
        out_follow_reg  <= out_follow_next;
        out_last_reg    <= out_last_next;
    end

    assign sym.ready         = (state_reg == ST_IDLE);
    assign code.valid        = out_valid_reg;
    assign code.bit_value    = out_bit_reg;
    assign code.follow_count = out_follow_reg;
    assign code.last         = out_last_reg;

`ifndef SYNTHESIS
    a_interval_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= high_reg)
        else $error("coding interval inverted");

    a_idle_straddles_half: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (high_reg[PRECISION-1] && !low_reg[PRECISION-1]))
        else $error("renormalisation left interval on one side of half");

    a_no_held_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held beat left behind at end of item");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && out_valid_next && out_last_next) |=> (state_reg == ST_IDLE))
        else $error("last beat issued while item still in progress");
`endif

endmodule

>>> tb/arithmetic_encoder_step_core_tb.sv
// self-checking testbench for the arithmetic encoder step core
`timescale 1ns / 1ps

module arithmetic_encoder_step_core_tb import arenc_pkg::*; ();

    localparam int COUNT_BITS = 16;
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;
    localparam logic [31:0] CODE_HALF = 32'h8000_0000;
    localparam logic [31:0] CODE_QUARTER = 32'h4000_0000;
    localparam logic [31:0] CODE_THREEQ = 32'hC000_0000;
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT = 5000;
    localparam int PREDICTED = -1;
    localparam int NO_BEAT = 0;
    localparam int ONE_BEAT = 1;
    localparam int N_DIR = 25;

    typedef enum logic [1:0] {
        OP_SYMBOL,
        OP_FINISH,
        OP_TOTAL
    } op_t;

    typedef struct packed {
        logic                bit_value;
        logic [FOLLOW_W-1:0] follow_count;
        logic                last;
    } code_beat_t;

    typedef struct {
        op_t         op;
        logic [15:0] a;
        logic [15:0] b;
        int          fixed;
        logic        bv;
        logic [15:0] fc;
        logic        lst;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [COUNT_BITS-1:0] cfg_wr_data;

    arenc_sym_if #(.COUNT_BITS(COUNT_BITS)) sym_ch ();
    arenc_code_if code_ch ();

    arithmetic_encoder_step_core #(
        .PRECISION  (32),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sym         (sym_ch),
        .code        (code_ch)
    );

    logic [31:0] lo_q;
    logic [31:0] hi_q;
    logic [15:0] defer_q;
    logic [15:0] total_q;
    code_beat_t  code_due [$];
    code_beat_t  fresh_beats [$];
    bit          failed;
    bit          burst;

    row_t dir_rows [N_DIR] = '{
        '{OP_FINISH, 16'd65534, 16'd65535, ONE_BEAT,  1'b0, 16'd1, 1'b1},
        '{OP_SYMBOL, 16'd0,     16'd256,   NO_BEAT,   1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd0,     16'd128,   ONE_BEAT,  1'b0, 16'd0, 1'b1},
        '{OP_SYMBOL, 16'd128,   16'd256,   ONE_BEAT,  1'b1, 16'd0, 1'b1},
        '{OP_SYMBOL, 16'd64,    16'd192,   NO_BEAT,   1'b0, 16'd0, 1'b0},
        '{OP_FINISH, 16'd0,     16'd1,     ONE_BEAT,  1'b0, 16'd2, 1'b1},
        '{OP_SYMBOL, 16'd0,     16'd1,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd255,   16'd256,   PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd300,   16'd65535, PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd0,     16'd0,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd200,   16'd100,   PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd65534, 16'd65535, PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_FINISH, 16'd0,     16'd0,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_TOTAL,  16'd0,     16'd0,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd0,     16'd1,     NO_BEAT,   1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd5,     16'd9,     NO_BEAT,   1'b0, 16'd0, 1'b0},
        '{OP_FINISH, 16'd0,     16'd0,     ONE_BEAT,  1'b0, 16'd1, 1'b1},
        '{OP_TOTAL,  16'd65535, 16'd0,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd0,     16'd1,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd65534, 16'd65535, PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd32767, 16'd32768, PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_FINISH, 16'd0,     16'd0,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_TOTAL,  16'd3,     16'd0,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_SYMBOL, 16'd1,     16'd2,     PREDICTED, 1'b0, 16'd0, 1'b0},
        '{OP_FINISH, 16'd0,     16'd0,     PREDICTED, 1'b0, 16'd0, 1'b0}
    };

    function automatic logic [63:0] scale_point(input logic [63:0] span,
                                                input logic [63:0] c,
                                                input logic [63:0] div);
        logic [63:0] q;
        logic [63:0] r;
        q = span / div;
        r = span % div;
        return q * c + (r * c) / div;
    endfunction

    task automatic emit_bit(input logic b);
        fresh_beats.push_back({b, defer_q, 1'b0});
        defer_q = '0;
    endtask

    task automatic predict_code(input logic f, input logic [15:0] cl_in,
                                input logic [15:0] ch_in);
        logic [63:0] div;
        logic [63:0] cl;
        logic [63:0] ch;
        logic [63:0] span;
        logic [63:0] lo_off;
        logic [63:0] hi_off;
        logic [63:0] lo_new;
        logic [63:0] hi_new;
        bit          done;
        fresh_beats = {};
        div = (total_q == 16'd0) ? 64'd1 : {48'd0, total_q};
        if (f == FUNC_FINISH)
        begin
            if (defer_q != PEND_MAX)
                defer_q = defer_q + 16'd1;
            fresh_beats.push_back({(lo_q >= CODE_QUARTER), defer_q, 1'b1});
            lo_q = '0;
            hi_q = '1;
            defer_q = '0;
            return;
        end
        cl = {48'd0, cl_in};
        ch = {48'd0, ch_in};
        if (ch > div)
            ch = div;
        if (ch == 64'd0)
            ch = 64'd1;
        if (cl >= ch)
            cl = ch - 64'd1;
        span = {32'd0, hi_q} - {32'd0, lo_q} + 64'd1;
        hi_off = scale_point(span, ch, div);
        lo_off = scale_point(span, cl, div);
        if (hi_off <= lo_off)
            hi_off = lo_off + 64'd1;
        hi_new = {32'd0, lo_q} + hi_off - 64'd1;
        lo_new = {32'd0, lo_q} + lo_off;
        hi_q = hi_new[31:0];
        lo_q = lo_new[31:0];
        done = 1'b0;
        while (!done)
        begin
            if (hi_q < CODE_HALF)
                emit_bit(1'b0);
            else if (lo_q >= CODE_HALF)
                emit_bit(1'b1);
            else if (lo_q >= CODE_QUARTER && hi_q < CODE_THREEQ)
            begin
                if (defer_q != PEND_MAX)
                    defer_q = defer_q + 16'd1;
                lo_q = lo_q - CODE_QUARTER;
                hi_q = hi_q - CODE_QUARTER;
            end
            else
                done = 1'b1;
            if (!done)
            begin
                lo_q = {lo_q[30:0], 1'b0};
                hi_q = {hi_q[30:0], 1'b1};
            end
        end
        if (fresh_beats.size() != 0)
            fresh_beats[fresh_beats.size() - 1].last = 1'b1;
    endtask

    task automatic send_item(input logic f, input logic [15:0] cl, input logic [15:0] ch,
                             input int fixed, input code_beat_t fixed_beat);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            sym_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sym_ch.valid <= 1'b1;
        sym_ch.func <= f;
        sym_ch.cum_low <= cl;
        sym_ch.cum_high <= ch;
        @(posedge clk);
        while (!sym_ch.ready) @(posedge clk);
        predict_code(f, cl, ch);
        if (fixed != PREDICTED)
        begin
            fresh_beats = {};
            if (fixed == ONE_BEAT)
                fresh_beats.push_back(fixed_beat);
        end
        foreach (fresh_beats[i])
            code_due.push_back(fresh_beats[i]);
    endtask

    task automatic quiesce();
        sym_ch.valid <= 1'b0;
        while (code_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_total(input logic [15:0] v);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        total_q = v;
    endtask

    // symbol of two counts whose sub-interval straddles the half point
    task automatic send_straddle();
        logic [63:0] span;
        logic [63:0] target;
        logic [63:0] c;
        span = {32'd0, hi_q} - {32'd0, lo_q} + 64'd1;
        target = {32'd0, CODE_HALF} - {32'd0, lo_q};
        c = target * total_q / span;
        while (c != 64'd0 && scale_point(span, c, total_q) >= target)
            c = c - 64'd1;
        while (c < total_q && scale_point(span, c + 64'd1, total_q) < target)
            c = c + 64'd1;
        if (c + 64'd2 > total_q)
            c = total_q - 64'd2;
        send_item(FUNC_ENCODE, c[15:0], c[15:0] + 16'd2, PREDICTED, '0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("arithmetic_encoder_step_core verification failed");
        $finish;
    end

    initial
    begin : code_sink
        int unsigned hold;
        code_beat_t  want;
        code_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            hold = burst ? 0 : $urandom_range(0, 5);
            if (hold != 0)
            begin
                code_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            code_ch.ready <= 1'b1;
            @(posedge clk);
            while (!code_ch.valid) @(posedge clk);
            if (code_due.size() == 0)
            begin
                $error("code beat with nothing expected: bit %0d follow %0d last %0d",
                       code_ch.bit_value, code_ch.follow_count, code_ch.last);
                failed = 1'b1;
            end
            else
            begin
                want = code_due.pop_front();
                if (code_ch.bit_value !== want.bit_value)
                begin
                    $error("bit_value: expected %0d, actual %0d",
                           want.bit_value, code_ch.bit_value);
                    failed = 1'b1;
                end
                if (code_ch.follow_count !== want.follow_count)
                begin
                    $error("follow_count: expected %0d, actual %0d",
                           want.follow_count, code_ch.follow_count);
                    failed = 1'b1;
                end
                if (code_ch.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, code_ch.last);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin : stimulus
        row_t        row;
        logic [15:0] cl;
        logic [15:0] ch;
        logic [15:0] div;
        logic [15:0] v;
        int unsigned pick;
        rst_n = 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        sym_ch.valid <= 1'b0;
        sym_ch.func <= FUNC_ENCODE;
        sym_ch.cum_low <= '0;
        sym_ch.cum_high <= '0;
        failed = 1'b0;
        burst = 1'b0;
        lo_q = '0;
        hi_q = '1;
        defer_q = '0;
        total_q = 16'(TOTAL_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            row = dir_rows[i];
            if (row.op == OP_TOTAL)
                set_total(row.a);
            else
                send_item((row.op == OP_FINISH) ? FUNC_FINISH : FUNC_ENCODE, row.a, row.b,
                          row.fixed, {row.bv, row.fc, row.lst});
        end

        // long runs of deferred bits, then flush them
        set_total(16'hFFFF);
        burst = 1'b1;
        repeat (6) send_straddle();
        send_item(FUNC_ENCODE, 16'd0, 16'd1, PREDICTED, '0);
        repeat (2) send_straddle();
        send_item(FUNC_FINISH, 16'd0, 16'd0, PREDICTED, '0);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: v = 16'hFFFF;
                1: v = 16'd1;
                2: v = 16'($urandom_range(2, 65535));
                3: v = 16'd2;
                4: v = 16'($urandom_range(1, 16));
                5: v = 16'd4096;
                6: v = 16'($urandom_range(1, 65535));
                default: v = 16'd0;
            endcase
            set_total(v);
            burst = (ph == 2 || ph == 5);
            div = (total_q == 16'd0) ? 16'd1 : total_q;
            for (int k = 0; k < 24; k++)
            begin
                if ((ph == 3 && k == 14) || $urandom_range(0, 99) < 3)
                    quiesce();
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    send_item(FUNC_FINISH, 16'($urandom), 16'($urandom), PREDICTED, '0);
                end
                else
                begin
                    if (pick < 18)
                    begin
                        cl = 16'($urandom_range(0, 65534));
                        ch = 16'($urandom_range(1, 65535));
                    end
                    else if (pick < 35)
                    begin
                        ch = 16'($urandom_range(1, div));
                        cl = ch - 16'd1;
                    end
                    else
                    begin
                        ch = 16'($urandom_range(1, div));
                        cl = 16'($urandom_range(0, ch - 1));
                    end
                    send_item(FUNC_ENCODE, cl, ch, PREDICTED, '0);
                end
            end
            if ($urandom_range(0, 1) == 1)
                send_item(FUNC_FINISH, 16'($urandom), 16'($urandom), PREDICTED, '0);
        end

        sym_ch.valid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && code_due.size() != 0; k++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (code_due.size() != 0)
        begin
            $error("%0d code beats never arrived", code_due.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("arithmetic_encoder_step_core verification clean");
        else
            $display("arithmetic_encoder_step_core verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/arenc_pkg.sv
rtl/arenc_if.sv
rtl/arenc_scale_lane.sv
rtl/arithmetic_encoder_step_core.sv
tb/arithmetic_encoder_step_core_tb.sv
